FILE: design/chb_pkg.sv
// ----------------------------------------------------------------------------
// chb_pkg: shared types and codes of the canonical Huffman code builder
// Holds result widths, status codes and the command bundle that the
// sequencer sends to the first-code table.
// ----------------------------------------------------------------------------
`default_nettype none

package chb_pkg;

    // Fixed field widths of the beats
    localparam int LEN_W    = 4;
    localparam int SYMBOL_W = 5;
    localparam int CODE_W   = 15;
    localparam int STATUS_W = 2;
    localparam int NEXT_W   = 16;
    localparam int LEN_SLOTS = 16;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_CODE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

    // Commands to the first-code table
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [LEN_W-1:0]  idx;
        logic [NEXT_W-1:0] operand;
    } chb_cmd_t;

endpackage

`default_nettype wire

FILE: design/chb_code_table.sv
// ----------------------------------------------------------------------------
// chb_code_table: first-code table with its shared adder
// Builds next(L) = (next(L-1) + count(L-1)) << 1 one length per command and
// steps the code of one length per emitted symbol, both on one 16-bit adder.
// ----------------------------------------------------------------------------
`default_nettype none

module chb_code_table (
    input  wire logic                        aclk,
    input  wire chb_pkg::chb_cmd_t           cmd,
    output logic [chb_pkg::NEXT_W-1:0]       rd_code
);

    logic [chb_pkg::NEXT_W-1:0] next_reg [chb_pkg::LEN_SLOTS];
    logic [chb_pkg::NEXT_W-1:0] acc_reg;
    logic [chb_pkg::NEXT_W-1:0] add_a;
    logic [chb_pkg::NEXT_W-1:0] add_sum;
    logic [chb_pkg::NEXT_W-1:0] build_val;

    // Read the code of the addressed length
    assign rd_code = next_reg[cmd.idx];

    // Shared adder: running code while building, table entry while stepping
    always_comb begin
        if (cmd.op == chb_pkg::CMD_BUILD) begin
            add_a = (cmd.idx == chb_pkg::LEN_W'(1)) ? '0 : acc_reg;
        end else begin
            add_a = rd_code;
        end
        add_sum   = add_a + cmd.operand;
        build_val = {add_sum[chb_pkg::NEXT_W-2:0], 1'b0};
    end

    // Write back the built or stepped code
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            chb_pkg::CMD_BUILD: begin
                next_reg[cmd.idx] <= build_val;
                acc_reg           <= build_val;
            end
            chb_pkg::CMD_STEP: begin
                next_reg[cmd.idx] <= add_sum;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/canonical_huffman_code_builder_unit.sv
// ----------------------------------------------------------------------------
// canonical_huffman_code_builder_unit: DEFLATE canonical code assignment
// Collects code lengths per symbol and emits symbol, code and length beats.
// ----------------------------------------------------------------------------
// Code lengths are taken one beat per cycle while the unit is loading. The
// beat flagged last closes the table: a start state decides between an error,
// an empty table and code assignment; assignment then forms the first code
// of every length from 1 to 15 on the shared adder, followed by a
// length-memory read and an emit step per stored symbol up to the last
// symbol with a non-zero length; a stalled result side holds the emit step.
// Input ready stays low from the last beat until the final result of the
// table has been placed in the output register.
`default_nettype none

module canonical_huffman_code_builder_unit #(
    parameter int MAX_SYMBOLS   = 32,
    parameter int MAX_CODE_BITS = 15
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [chb_pkg::LEN_W-1:0]      s_code_length,
    input  wire logic                           s_last,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [chb_pkg::SYMBOL_W-1:0]        m_symbol,
    output logic [chb_pkg::CODE_W-1:0]          m_code,
    output logic [chb_pkg::LEN_W-1:0]           m_code_bits,
    output logic [chb_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_end_of_table
);

    localparam int ADDR_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int LEN_W  = chb_pkg::LEN_W;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_BUILD = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // Control state
    logic [2:0]        state_reg,   state_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic              ovf_reg,     ovf_next;
    logic              long_reg,    long_next;
    logic              any_reg,     any_next;
    logic [ADDR_W-1:0] last_nz_reg, last_nz_next;
    logic [CNT_W-1:0]  hist_reg  [1:15];
    logic [CNT_W-1:0]  hist_next [1:15];
    logic [LEN_W-1:0]  len_idx_reg, len_idx_next;
    logic [ADDR_W-1:0] sym_idx_reg, sym_idx_next;
    logic              m_valid_reg, m_valid_next;

    // Payload
    logic [LEN_W-1:0]               len_mem [MAX_SYMBOLS];
    logic [LEN_W-1:0]               rd_len_reg;
    logic [chb_pkg::SYMBOL_W-1:0]   m_symbol_reg, m_symbol_next;
    logic [chb_pkg::CODE_W-1:0]     m_code_reg,   m_code_next;
    logic [LEN_W-1:0]               m_bits_reg,   m_bits_next;
    logic [chb_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic                           m_end_reg,    m_end_next;

    logic                       in_fire;
    logic                       slot_free;
    logic                       store_ok;
    logic                       len_long;
    logic                       clear_tab;
    chb_pkg::chb_cmd_t          cmd;
    logic [chb_pkg::NEXT_W-1:0] rd_code;

    assign s_ready        = (state_reg == S_LOAD);
    assign in_fire        = s_valid && s_ready;
    assign slot_free      = !m_valid_reg || m_ready;
    assign store_ok       = !ovf_reg && (cnt_reg < CNT_W'(MAX_SYMBOLS));
    assign len_long       = {1'b0, s_code_length} > (LEN_W+1)'(MAX_CODE_BITS);

    assign m_valid        = m_valid_reg;
    assign m_symbol       = m_symbol_reg;
    assign m_code         = m_code_reg;
    assign m_code_bits    = m_bits_reg;
    assign m_status       = m_status_reg;
    assign m_end_of_table = m_end_reg;

    // First-code table and shared adder
    chb_code_table u_table (
        .aclk    (aclk),
        .cmd     (cmd),
        .rd_code (rd_code)
    );

    // Sequencer and output register
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        long_next     = long_reg;
        any_next      = any_reg;
        last_nz_next  = last_nz_reg;
        len_idx_next  = len_idx_reg;
        sym_idx_next  = sym_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_symbol_next = m_symbol_reg;
        m_code_next   = m_code_reg;
        m_bits_next   = m_bits_reg;
        m_status_next = m_status_reg;
        m_end_next    = m_end_reg;
        clear_tab     = 1'b0;
        cmd.op        = chb_pkg::CMD_NONE;
        cmd.idx       = rd_len_reg;
        cmd.operand   = chb_pkg::NEXT_W'(1);

        unique case (state_reg)
            S_LOAD: begin
                if (in_fire) begin
                    if (!ovf_reg && !store_ok) begin
                        ovf_next = 1'b1;
                    end else if (store_ok) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (len_long) begin
                            long_next = 1'b1;
                        end
                        if (s_code_length != '0) begin
                            any_next     = 1'b1;
                            last_nz_next = cnt_reg[ADDR_W-1:0];
                        end
                    end
                    if (s_last) begin
                        state_next = S_START;
                    end
                end
            end
            S_START: begin
                if (ovf_reg || long_reg || !any_reg) begin
                    // Single-beat outcome: error or empty table
                    if (slot_free) begin
                        m_valid_next  = 1'b1;
                        m_symbol_next = '0;
                        m_code_next   = '0;
                        m_bits_next   = '0;
                        m_end_next    = 1'b1;
                        if (ovf_reg) begin
                            m_status_next = chb_pkg::ST_OVERFLOW;
                        end else if (long_reg) begin
                            m_status_next = chb_pkg::ST_TOO_LONG;
                        end else begin
                            m_status_next = chb_pkg::ST_EMPTY;
                        end
                        clear_tab  = 1'b1;
                        state_next = S_LOAD;
                    end
                end else begin
                    len_idx_next = LEN_W'(1);
                    state_next   = S_BUILD;
                end
            end
            S_BUILD: begin
                // One length per cycle through the shared adder
                cmd.op  = chb_pkg::CMD_BUILD;
                cmd.idx = len_idx_reg;
                if (len_idx_reg >= LEN_W'(2)) begin
                    cmd.operand = chb_pkg::NEXT_W'(hist_reg[len_idx_reg - LEN_W'(1)]);
                end else begin
                    cmd.operand = '0;
                end
                if (len_idx_reg == LEN_W'(15)) begin
                    sym_idx_next = '0;
                    state_next   = S_READ;
                end else begin
                    len_idx_next = len_idx_reg + LEN_W'(1);
                end
            end
            S_READ: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (rd_len_reg == '0) begin
                    sym_idx_next = sym_idx_reg + ADDR_W'(1);
                    state_next   = S_READ;
                end else if (slot_free) begin
                    cmd.op        = chb_pkg::CMD_STEP;
                    m_valid_next  = 1'b1;
                    m_symbol_next = chb_pkg::SYMBOL_W'(sym_idx_reg);
                    m_code_next   = rd_code[chb_pkg::CODE_W-1:0];
                    m_bits_next   = rd_len_reg;
                    m_status_next = chb_pkg::ST_CODE;
                    m_end_next    = (sym_idx_reg == last_nz_reg);
                    if (sym_idx_reg == last_nz_reg) begin
                        clear_tab  = 1'b1;
                        state_next = S_LOAD;
                    end else begin
                        sym_idx_next = sym_idx_reg + ADDR_W'(1);
                        state_next   = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase

        // Drop the table summary once its last beat is loaded into the output register
        if (clear_tab) begin
            cnt_next  = '0;
            ovf_next  = 1'b0;
            long_next = 1'b0;
            any_next  = 1'b0;
        end
    end

    // Count lengths per slot
    always_comb begin
        for (int i = 1; i < chb_pkg::LEN_SLOTS; i++) begin
            if (clear_tab) begin
                hist_next[i] = '0;
            end else if (in_fire && store_ok && !len_long &&
                         (s_code_length == LEN_W'(i))) begin
                hist_next[i] = hist_reg[i] + CNT_W'(1);
            end else begin
                hist_next[i] = hist_reg[i];
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            long_reg    <= 1'b0;
            any_reg     <= 1'b0;
            last_nz_reg <= '0;
            len_idx_reg <= '0;
            sym_idx_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 1; i < chb_pkg::LEN_SLOTS; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            long_reg    <= long_next;
            any_reg     <= any_next;
            last_nz_reg <= last_nz_next;
            len_idx_reg <= len_idx_next;
            sym_idx_reg <= sym_idx_next;
            m_valid_reg <= m_valid_next;
            for (int i = 1; i < chb_pkg::LEN_SLOTS; i++) begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_symbol_reg <= m_symbol_next;
        m_code_reg   <= m_code_next;
        m_bits_reg   <= m_bits_next;
        m_status_reg <= m_status_next;
        m_end_reg    <= m_end_next;
    end

    // Length memory: write on load, registered read at the walk index
    always_ff @(posedge aclk) begin
        if (in_fire && store_ok) begin
            len_mem[cnt_reg[ADDR_W-1:0]] <= s_code_length;
        end
        rd_len_reg <= len_mem[sym_idx_reg];
    end

endmodule

`default_nettype wire

FILE: design/chb_checker.sv
// ----------------------------------------------------------------------------
// chb_checker: port-level checks of the canonical Huffman code builder
// Watches the beats on both channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chb_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           s_last,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [chb_pkg::SYMBOL_W-1:0]   m_symbol,
    input wire logic [chb_pkg::CODE_W-1:0]     m_code,
    input wire logic [chb_pkg::LEN_W-1:0]      m_code_bits,
    input wire logic [chb_pkg::STATUS_W-1:0]   m_status,
    input wire logic                           m_end_of_table
);

    // No result beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A closing beat takes input ready low
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("length accepted right after the last beat");

    // Non-code outcomes are single closing beats with empty fields
    a_status_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != chb_pkg::ST_CODE) |->
            m_end_of_table && (m_symbol == '0) && (m_code == '0) &&
            (m_code_bits == '0))
        else $error("malformed status beat");

    // A code beat always carries a non-zero length
    a_code_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == chb_pkg::ST_CODE) |-> (m_code_bits != '0))
        else $error("code beat with zero length");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol) && $stable(m_code) &&
            $stable(m_code_bits) && $stable(m_status) && $stable(m_end_of_table))
        else $error("stalled result changed");

endmodule

bind canonical_huffman_code_builder_unit chb_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last         (s_last),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_symbol       (m_symbol),
    .m_code         (m_code),
    .m_code_bits    (m_code_bits),
    .m_status       (m_status),
    .m_end_of_table (m_end_of_table)
);

`default_nettype wire
